// ----- hdl/idv_pkg.sv -----
// ----------------------------------------------------------------------------
// idv_pkg
// Shared types, constants and helper functions for the identity number
// validator: request/result payloads, sequencer states, shared unit controls.
// ----------------------------------------------------------------------------
`default_nettype none

package idv_pkg;

  // Region table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int REGION_W = 20;
  localparam int YEAR_W   = 14;
  localparam int MD_W     = 7;
  localparam int SEQ_W    = 10;
  localparam int POS_W    = 5;
  localparam int UNIT_W   = 20;

  // Position of the check character
  localparam logic [POS_W-1:0] POS_CHECK = 5'd17;

  // Year range defaults
  localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 14'd1900;
  localparam logic [YEAR_W-1:0] MAX_YEAR_RESET = 14'd2011;

  // Character codes
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_X    = 8'h58;

  // Request opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_CHAR   = 2'd2;

  // Verdict codes
  localparam logic [1:0] VERDICT_INVALID = 2'd0;
  localparam logic [1:0] VERDICT_MALE    = 2'd1;
  localparam logic [1:0] VERDICT_FEMALE  = 2'd2;

  // Check value that is written as X
  localparam logic [3:0] CHECK_X = 4'd10;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_YEAR = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_YEAR = 1'b1;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [REGION_W-1:0] region_value;
    logic [7:0]          char_code;
  } req_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [3:0] expected_check;
  } rsp_t;

  // Shared unit operations
  typedef enum logic [1:0] {
    UOP_MULADD,
    UOP_MOD11,
    UOP_LE,
    UOP_EQ
  } uop_t;

  typedef struct packed {
    uop_t              op;
    logic [UNIT_W-1:0] a;
    logic [3:0]        m;
    logic [UNIT_W-1:0] c;
  } unit_req_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_WMUL,
    ST_MOD,
    ST_EXP,
    ST_YMIN,
    ST_YMAX,
    ST_DAY,
    ST_RD,
    ST_CMP,
    ST_DONE
  } seq_state_t;

  // Number field that a character position feeds
  typedef enum logic [2:0] {
    FLD_REGION,
    FLD_YEAR,
    FLD_MONTH,
    FLD_DAY,
    FLD_SEQ
  } field_t;

  function automatic field_t field_of(input logic [POS_W-1:0] pos);
    field_t f;
    if (pos < 5'd6) begin
      f = FLD_REGION;
    end else if (pos < 5'd10) begin
      f = FLD_YEAR;
    end else if (pos < 5'd12) begin
      f = FLD_MONTH;
    end else if (pos < 5'd14) begin
      f = FLD_DAY;
    end else begin
      f = FLD_SEQ;
    end
    return f;
  endfunction

  // Power-of-two weight mod 11 for each digit position
  function automatic logic [3:0] digit_weight(input logic [POS_W-1:0] pos);
    logic [3:0] w;
    case (pos)
      5'd0:    w = 4'd7;
      5'd1:    w = 4'd9;
      5'd2:    w = 4'd10;
      5'd3:    w = 4'd5;
      5'd4:    w = 4'd8;
      5'd5:    w = 4'd4;
      5'd6:    w = 4'd2;
      5'd7:    w = 4'd1;
      5'd8:    w = 4'd6;
      5'd9:    w = 4'd3;
      5'd10:   w = 4'd7;
      5'd11:   w = 4'd9;
      5'd12:   w = 4'd10;
      5'd13:   w = 4'd5;
      5'd14:   w = 4'd8;
      5'd15:   w = 4'd4;
      5'd16:   w = 4'd2;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  // Gregorian leap year from the four decimal digits (thousands first).
  // 10 is 2 mod 4, so a two-digit pair mod 4 is (2*tens + units) mod 4.
  function automatic logic is_leap(input logic [3:0] y3, input logic [3:0] y2,
                                   input logic [3:0] y1, input logic [3:0] y0);
    logic [1:0] lo4;
    logic [1:0] hi4;
    lo4 = {y1[0], 1'b0} + y0[1:0];
    hi4 = {y3[0], 1'b0} + y2[1:0];
    return (lo4 == 2'd0) && ((y1 != 4'd0) || (y0 != 4'd0) || (hi4 == 2'd0));
  endfunction

  function automatic logic [MD_W-1:0] last_day(input logic [MD_W-1:0] month,
                                               input logic leap);
    logic [MD_W-1:0] d;
    case (month) inside
      7'd2:                    d = leap ? 7'd29 : 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11: d = 7'd30;
      default:                 d = 7'd31;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/idv_unit.sv -----
// ----------------------------------------------------------------------------
// idv_unit
// Shared arithmetic unit: multiply-add, reduce mod 11, compare.
// ----------------------------------------------------------------------------
`default_nettype none

module idv_unit (
  input  idv_pkg::unit_req_t              req,
  output logic [idv_pkg::UNIT_W-1:0]      result
);

  logic [23:0] prod_sum;
  logic [14:0] recip;
  logic [3:0]  quot;
  logic [6:0]  rem_raw;
  logic [6:0]  rem_fix;

  // Multiply-add on the full operand
  assign prod_sum = 24'(req.a) * 24'(req.m) + 24'(req.c);

  // Mod 11 of a small value by reciprocal (187/2048), then one correction
  assign recip   = 15'(req.a[6:0]) * 15'd187;
  assign quot    = recip[14:11];
  assign rem_raw = req.a[6:0] - 7'({3'b000, quot} * 7'd11);
  assign rem_fix = (rem_raw >= 7'd11) ? (rem_raw - 7'd11) : rem_raw;

  // Select the operation
  always_comb begin
    unique case (req.op)
      idv_pkg::UOP_MULADD: result = prod_sum[idv_pkg::UNIT_W-1:0];
      idv_pkg::UOP_MOD11:  result = idv_pkg::UNIT_W'(rem_fix);
      idv_pkg::UOP_LE:     result = idv_pkg::UNIT_W'(req.a <= req.c);
      idv_pkg::UOP_EQ:     result = idv_pkg::UNIT_W'(req.a == req.c);
      default:             result = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/idv_region_ram.sv -----
// ----------------------------------------------------------------------------
// idv_region_ram
// Region code table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module idv_region_ram (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [idv_pkg::TABLE_AW-1:0]       wr_addr,
  input  logic [idv_pkg::REGION_W-1:0]       wr_data,
  input  logic                               rd_en,
  input  logic [idv_pkg::TABLE_AW-1:0]       rd_addr,
  output logic [idv_pkg::REGION_W-1:0]       rd_data
);

  logic [idv_pkg::REGION_W-1:0] mem [idv_pkg::TABLE_DEPTH];

  // Write an appended entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/id_number_validator_top.sv -----
// ----------------------------------------------------------------------------
// id_number_validator_top
// Checks an 18-character identity number: region table lookup, date and
// year range, sequence and ISO 7064 MOD 11-2 check character.
// ----------------------------------------------------------------------------
//
//   channel  | signals                          | moves
//   ---------+----------------------------------+-------------------------------
//   req      | req_valid, req_stall, req_data   | opcode, region code, character
//   rsp      | rsp_valid, rsp_stall, rsp_data   | verdict, expected check value
//   cfg      | cfg_write, cfg_index, cfg_data   | min_year, max_year writes
//
// Table requests and non-digit characters need no sequencer pass. A digit is
// accepted, then accumulated, weighted and reduced mod 11 in the shared unit.
// The check character finds the expected value, checks the year range and the
// day and, if all fields pass, scans the table over the single read port of the
// region RAM, stopping on a hit; a bad character seen earlier skips all this.
// Reset restores the year range and empties the table; no clearing pass.
// A result waiting on rsp_stall holds the sequencer in its final state only
// when the next result is ready; other requests are taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module id_number_validator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  idv_pkg::req_t                       req_data,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output idv_pkg::rsp_t                       rsp_data,
  input  logic                                cfg_write,
  input  logic [idv_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [idv_pkg::YEAR_W-1:0]          cfg_data
);

  idv_pkg::seq_state_t state;
  idv_pkg::seq_state_t state_next;

  // Configuration
  logic [idv_pkg::YEAR_W-1:0]   min_year;
  logic [idv_pkg::YEAR_W-1:0]   max_year;

  // Number in progress
  logic [idv_pkg::POS_W-1:0]    char_position;
  logic [idv_pkg::REGION_W-1:0] region_accum;
  logic [idv_pkg::YEAR_W-1:0]   year_accum;
  logic [idv_pkg::MD_W-1:0]     month_accum;
  logic [idv_pkg::MD_W-1:0]     day_accum;
  logic [idv_pkg::SEQ_W-1:0]    sequence_accum;
  logic [3:0]                   weighted_residue;
  logic                         bad_char_seen;
  logic [3:0]                   year_digit [4];

  // Table
  logic [idv_pkg::COUNT_W-1:0]  entry_count;
  logic [idv_pkg::TABLE_AW-1:0] scan_idx;
  logic [idv_pkg::REGION_W-1:0] ram_q;
  logic                         ram_wr;
  logic                         ram_rd;

  // Working registers
  logic [3:0]                   digit;
  logic [6:0]                   wsum;
  logic [7:0]                   check_char;
  logic [3:0]                   expect_val;
  logic                         fields_ok;
  logic                         region_hit;

  // Shared unit
  idv_pkg::unit_req_t           ureq;
  logic [idv_pkg::UNIT_W-1:0]   ures;

  logic                         accept;
  logic                         is_digit;
  logic                         at_check;
  logic                         slot_free;
  logic                         leap;
  logic [idv_pkg::MD_W-1:0]     month_last;
  logic                         char_match;
  logic                         scan_last;
  idv_pkg::field_t              fld;
  logic [1:0]                   verdict_final;

  assign req_stall = (state != idv_pkg::ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign is_digit  = (req_data.char_code >= idv_pkg::CHAR_ZERO) &&
                     (req_data.char_code <= idv_pkg::CHAR_NINE);
  assign at_check  = (char_position == idv_pkg::POS_CHECK);
  assign slot_free = !rsp_valid || !rsp_stall;
  assign fld       = idv_pkg::field_of(char_position);

  assign leap       = idv_pkg::is_leap(year_digit[0], year_digit[1],
                                       year_digit[2], year_digit[3]);
  assign month_last = idv_pkg::last_day(month_accum, leap);
  assign char_match = (expect_val == idv_pkg::CHECK_X) ?
                      (check_char == idv_pkg::CHAR_X) :
                      (check_char == (idv_pkg::CHAR_ZERO + 8'(expect_val)));
  assign scan_last  = ({1'b0, scan_idx} + idv_pkg::COUNT_W'(1)) == entry_count;

  assign verdict_final = (fields_ok && region_hit && char_match) ?
                         (sequence_accum[0] ? idv_pkg::VERDICT_MALE :
                                              idv_pkg::VERDICT_FEMALE) :
                         idv_pkg::VERDICT_INVALID;

  assign ram_wr = accept && (req_data.opcode == idv_pkg::OP_APPEND) &&
                  (entry_count < idv_pkg::COUNT_W'(idv_pkg::TABLE_DEPTH));

  idv_unit u_unit (
    .req    (ureq),
    .result (ures)
  );

  idv_region_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (entry_count[idv_pkg::TABLE_AW-1:0]),
    .wr_data (req_data.region_value),
    .rd_en   (ram_rd),
    .rd_addr (scan_idx),
    .rd_data (ram_q)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= idv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and shared unit operands
  always_comb begin
    state_next = state;
    ureq.op    = idv_pkg::UOP_MULADD;
    ureq.a     = '0;
    ureq.m     = '0;
    ureq.c     = '0;
    ram_rd     = 1'b0;
    unique case (state)
      idv_pkg::ST_IDLE: begin
        if (accept && (req_data.opcode == idv_pkg::OP_CHAR)) begin
          if (at_check) begin
            state_next = bad_char_seen ? idv_pkg::ST_DONE : idv_pkg::ST_EXP;
          end else if (is_digit) begin
            state_next = idv_pkg::ST_MAC;
          end
        end
      end
      idv_pkg::ST_MAC: begin
        ureq.m = 4'd10;
        ureq.c = idv_pkg::UNIT_W'(digit);
        unique case (fld)
          idv_pkg::FLD_REGION: ureq.a = region_accum;
          idv_pkg::FLD_YEAR:   ureq.a = idv_pkg::UNIT_W'(year_accum);
          idv_pkg::FLD_MONTH:  ureq.a = idv_pkg::UNIT_W'(month_accum);
          idv_pkg::FLD_DAY:    ureq.a = idv_pkg::UNIT_W'(day_accum);
          default:             ureq.a = idv_pkg::UNIT_W'(sequence_accum);
        endcase
        state_next = idv_pkg::ST_WMUL;
      end
      idv_pkg::ST_WMUL: begin
        ureq.a     = idv_pkg::UNIT_W'(digit);
        ureq.m     = idv_pkg::digit_weight(char_position);
        ureq.c     = idv_pkg::UNIT_W'(weighted_residue);
        state_next = idv_pkg::ST_MOD;
      end
      idv_pkg::ST_MOD: begin
        ureq.op    = idv_pkg::UOP_MOD11;
        ureq.a     = idv_pkg::UNIT_W'(wsum);
        state_next = idv_pkg::ST_IDLE;
      end
      idv_pkg::ST_EXP: begin
        ureq.op    = idv_pkg::UOP_MOD11;
        ureq.a     = idv_pkg::UNIT_W'(4'd12 - weighted_residue);
        state_next = idv_pkg::ST_YMIN;
      end
      idv_pkg::ST_YMIN: begin
        ureq.op    = idv_pkg::UOP_LE;
        ureq.a     = idv_pkg::UNIT_W'(min_year);
        ureq.c     = idv_pkg::UNIT_W'(year_accum);
        state_next = idv_pkg::ST_YMAX;
      end
      idv_pkg::ST_YMAX: begin
        ureq.op    = idv_pkg::UOP_LE;
        ureq.a     = idv_pkg::UNIT_W'(year_accum);
        ureq.c     = idv_pkg::UNIT_W'(max_year);
        state_next = idv_pkg::ST_DAY;
      end
      idv_pkg::ST_DAY: begin
        ureq.op = idv_pkg::UOP_LE;
        ureq.a  = idv_pkg::UNIT_W'(day_accum);
        ureq.c  = idv_pkg::UNIT_W'(month_last);
        if (fields_ok && ures[0] && (entry_count != '0)) begin
          state_next = idv_pkg::ST_RD;
        end else begin
          state_next = idv_pkg::ST_DONE;
        end
      end
      idv_pkg::ST_RD: begin
        ram_rd     = 1'b1;
        state_next = idv_pkg::ST_CMP;
      end
      idv_pkg::ST_CMP: begin
        ureq.op = idv_pkg::UOP_EQ;
        ureq.a  = ram_q;
        ureq.c  = region_accum;
        if (ures[0] || scan_last) begin
          state_next = idv_pkg::ST_DONE;
        end else begin
          state_next = idv_pkg::ST_RD;
        end
      end
      idv_pkg::ST_DONE: begin
        if (slot_free) begin
          state_next = idv_pkg::ST_IDLE;
        end
      end
      default: state_next = idv_pkg::ST_IDLE;
    endcase
  end

  // Year range registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= idv_pkg::MIN_YEAR_RESET;
      max_year <= idv_pkg::MAX_YEAR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        idv_pkg::CFG_MIN_YEAR: min_year <= cfg_data;
        idv_pkg::CFG_MAX_YEAR: max_year <= cfg_data;
        default: ;
      endcase
    end
  end

  // Number state and entry count: accumulate digits, count appends, restart after a result or a clear
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position    <= '0;
      region_accum     <= '0;
      year_accum       <= '0;
      month_accum      <= '0;
      day_accum        <= '0;
      sequence_accum   <= '0;
      weighted_residue <= '0;
      bad_char_seen    <= 1'b0;
      entry_count      <= '0;
    end else begin
      unique case (state)
        idv_pkg::ST_IDLE: begin
          if (accept) begin
            if (req_data.opcode == idv_pkg::OP_CLEAR) begin
              entry_count      <= '0;
              char_position    <= '0;
              region_accum     <= '0;
              year_accum       <= '0;
              month_accum      <= '0;
              day_accum        <= '0;
              sequence_accum   <= '0;
              weighted_residue <= '0;
              bad_char_seen    <= 1'b0;
            end else if (ram_wr) begin
              entry_count <= entry_count + idv_pkg::COUNT_W'(1);
            end else if ((req_data.opcode == idv_pkg::OP_CHAR) && !at_check &&
                         !is_digit) begin
              bad_char_seen <= 1'b1;
              char_position <= char_position + idv_pkg::POS_W'(1);
            end
          end
        end
        idv_pkg::ST_MAC: begin
          unique case (fld)
            idv_pkg::FLD_REGION: region_accum   <= ures;
            idv_pkg::FLD_YEAR:   year_accum     <= ures[idv_pkg::YEAR_W-1:0];
            idv_pkg::FLD_MONTH:  month_accum    <= ures[idv_pkg::MD_W-1:0];
            idv_pkg::FLD_DAY:    day_accum      <= ures[idv_pkg::MD_W-1:0];
            default:             sequence_accum <= ures[idv_pkg::SEQ_W-1:0];
          endcase
        end
        idv_pkg::ST_MOD: begin
          weighted_residue <= ures[3:0];
          char_position    <= char_position + idv_pkg::POS_W'(1);
        end
        idv_pkg::ST_DONE: begin
          if (slot_free) begin
            char_position    <= '0;
            region_accum     <= '0;
            year_accum       <= '0;
            month_accum      <= '0;
            day_accum        <= '0;
            sequence_accum   <= '0;
            weighted_residue <= '0;
            bad_char_seen    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers for the current request
  always_ff @(posedge clk) begin
    unique case (state)
      idv_pkg::ST_IDLE: begin
        if (accept && (req_data.opcode == idv_pkg::OP_CHAR)) begin
          digit      <= req_data.char_code[3:0];
          check_char <= req_data.char_code;
          scan_idx   <= '0;
          region_hit <= 1'b0;
          expect_val <= '0;
          fields_ok  <= (month_accum >= 7'd1) && (month_accum <= 7'd12) &&
                        (day_accum != '0) && (sequence_accum != '0) &&
                        !bad_char_seen;
          if (!at_check && is_digit && (fld == idv_pkg::FLD_YEAR)) begin
            year_digit[2'(char_position - 5'd6)] <= req_data.char_code[3:0];
          end
        end
      end
      idv_pkg::ST_WMUL: wsum       <= ures[6:0];
      idv_pkg::ST_EXP:  expect_val <= ures[3:0];
      idv_pkg::ST_YMIN: fields_ok  <= fields_ok && ures[0];
      idv_pkg::ST_YMAX: fields_ok  <= fields_ok && ures[0];
      idv_pkg::ST_DAY:  fields_ok  <= fields_ok && ures[0];
      idv_pkg::ST_CMP: begin
        if (ures[0]) begin
          region_hit <= 1'b1;
        end else if (!scan_last) begin
          scan_idx <= scan_idx + idv_pkg::TABLE_AW'(1);
        end
      end
      default: ;
    endcase
  end

  // Result register: load when the slot is free, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == idv_pkg::ST_DONE) && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == idv_pkg::ST_DONE) && slot_free) begin
      rsp_data.verdict        <= verdict_final;
      rsp_data.expected_check <= expect_val;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/idv_checker.sv -----
// ----------------------------------------------------------------------------
// idv_checker
// Port-level checks on the validator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module idv_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  idv_pkg::req_t req_data,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  idv_pkg::rsp_t rsp_data
);

  // No result straight after reset
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed");

  // Verdict and check value stay in range
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.verdict != 2'd3) && (rsp_data.expected_check <= 4'd10))
    else $error("result field out of range");

  // A table request leaves the block ready in the following cycle
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall &&
    ((req_data.opcode == idv_pkg::OP_CLEAR) || (req_data.opcode == idv_pkg::OP_APPEND))
    |=> !req_stall)
    else $error("table request held the block busy");

  // Raise a new result only after the sequencer has been busy
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result appeared without sequencer activity");

endmodule

bind id_number_validator_top idv_checker u_idv_checker (.*);

`default_nettype wire

// ----- tb/id_number_validator_top_tb.sv -----
// ----------------------------------------------------------------------------
// id_number_validator_top_tb
// Self-checking bench for the identity number validator. Loads region tables
// and streams identity characters over the request channel. An in-bench
// predictor works out every verdict and check value, and each result is
// compared in order. Directed numbers cover dates, leap years, the year range,
// table depth and bad characters. Long runs of mostly well-formed random
// numbers follow, under varying idle and back-pressure.
// ----------------------------------------------------------------------------
module id_number_validator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import idv_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [7:0] CHAR_LOWER_X = 8'h78;
  localparam int         ID_CHARS      = 18;
  localparam int         SETTLE_CYCLES = 200;
  localparam int         QUIET_LIMIT   = 20000;
  localparam int         HOLD_CYCLES   = 1500;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  req_t                   req_data  = '0;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  rsp_t                   rsp_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_MIN_YEAR;
  logic [YEAR_W-1:0]      cfg_data  = '0;

  // Predictor state
  int unsigned         yr_min;
  int unsigned         yr_max;
  int unsigned         cur_pos;
  int unsigned         cur_region;
  int unsigned         cur_year;
  int unsigned         cur_month;
  int unsigned         cur_day;
  int unsigned         cur_seq;
  int unsigned         cur_residue;
  bit                  cur_bad;
  logic [REGION_W-1:0] region_tbl [TABLE_DEPTH];
  int unsigned         n_regions;
  int unsigned         pos_weight [17];
  rsp_t                pending_verdicts [$];

  // Stimulus state
  logic [7:0]  id_buf [ID_CHARS];
  int unsigned loaded_regions [$];
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int          hold_left;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  int unsigned error_count;
  bit          xfer_seen;

  id_number_validator_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void restart_number();
    cur_pos     = 0;
    cur_region  = 0;
    cur_year    = 0;
    cur_month   = 0;
    cur_day     = 0;
    cur_seq     = 0;
    cur_residue = 0;
    cur_bad     = 1'b0;
  endfunction

  function automatic bit region_known(input int unsigned code);
    for (int i = 0; i < n_regions; i++) begin
      if (region_tbl[i] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    if (m == 2) begin
      return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic bit date_valid(input int unsigned y, input int unsigned m,
                                    input int unsigned d);
    if (y < yr_min || y > yr_max) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    return (d >= 1) && (d <= month_length(y, m));
  endfunction

  // Advance the predicted number by one accepted request
  function automatic void predict_verdict(input req_t r);
    int unsigned d;
    int unsigned chk;
    bit          match;
    rsp_t        res;
    case (r.opcode)
      OP_CLEAR: begin
        n_regions = 0;
        restart_number();
      end
      OP_APPEND: begin
        if (n_regions < TABLE_DEPTH) begin
          region_tbl[n_regions] = r.region_value;
          n_regions++;
        end
      end
      OP_CHAR: begin
        if (cur_pos < POS_CHECK) begin
          if (r.char_code >= CHAR_ZERO && r.char_code <= CHAR_NINE) begin
            d = r.char_code - CHAR_ZERO;
            cur_residue = (cur_residue + d * pos_weight[cur_pos]) % 11;
            if (cur_pos < 6) begin
              cur_region = cur_region * 10 + d;
            end else if (cur_pos < 10) begin
              cur_year = cur_year * 10 + d;
            end else if (cur_pos < 12) begin
              cur_month = cur_month * 10 + d;
            end else if (cur_pos < 14) begin
              cur_day = cur_day * 10 + d;
            end else begin
              cur_seq = cur_seq * 10 + d;
            end
          end else begin
            cur_bad = 1'b1;
          end
          cur_pos++;
        end else begin
          chk = 0;
          res.verdict = VERDICT_INVALID;
          if (!cur_bad) begin
            chk = (12 - cur_residue) % 11;
            if (chk == CHECK_X) begin
              match = (r.char_code == CHAR_X);
            end else begin
              match = (r.char_code == CHAR_ZERO + chk);
            end
            if (match && region_known(cur_region) && cur_seq != 0 &&
                date_valid(cur_year, cur_month, cur_day)) begin
              res.verdict = cur_seq[0] ? VERDICT_MALE : VERDICT_FEMALE;
            end
          end
          res.expected_check = chk[3:0];
          pending_verdicts.push_back(res);
          restart_number();
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (pending_verdicts.size() == 0) begin
      report_error($sformatf("result verdict %0d check %0d with nothing pending",
                             got.verdict, got.expected_check));
    end else begin
      want = pending_verdicts.pop_front();
      if (got.verdict !== want.verdict) begin
        report_error($sformatf("verdict %0d, want %0d", got.verdict, want.verdict));
      end
      if (got.expected_check !== want.expected_check) begin
        report_error($sformatf("expected_check %0d, want %0d",
                               got.expected_check, want.expected_check));
      end
    end
  endtask

  // Sample both channels and watch for a stuck block
  always @(posedge clk) begin
    if (!rst) begin
      xfer_seen = 1'b0;
      if (req_valid && !req_stall) begin
        predict_verdict(req_data);
        xfer_seen = 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
        check_result(rsp_data);
        xfer_seen = 1'b1;
      end
      quiet_cycles = xfer_seen ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_verdicts.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver stall: a long hold when asked, random otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic req_t make_req(input int unsigned op, input int unsigned rv,
                                    input int unsigned ch);
    req_t r;
    r.opcode       = op[1:0];
    r.region_value = rv[REGION_W-1:0];
    r.char_code    = ch[7:0];
    return r;
  endfunction

  // Offer one request, with random idle cycles ahead of it; return once taken
  task automatic send_req(input req_t r);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (r.opcode != OP_UNUSED) items_sent++;
  endtask

  task automatic drop_req();
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  // Wait until every result is in and the block has had time to go idle
  task automatic wait_quiet();
    drop_req();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[YEAR_W-1:0];
    @(posedge clk);
    if (idx == CFG_MIN_YEAR) begin
      yr_min = val % (1 << YEAR_W);
    end else begin
      yr_max = val % (1 << YEAR_W);
    end
  endtask

  task automatic set_year_range(input int unsigned lo, input int unsigned hi);
    wait_quiet();
    write_reg(CFG_MIN_YEAR, lo);
    write_reg(CFG_MAX_YEAR, hi);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic void put_digits(input int first, input int count,
                                     input int unsigned value);
    int unsigned v;
    v = value;
    for (int i = count - 1; i >= 0; i--) begin
      id_buf[first + i] = 8'(CHAR_ZERO + v % 10);
      v = v / 10;
    end
  endfunction

  // Build a well-formed number with its correct check character
  function automatic void compose_id(input int unsigned region, year, month, day, seq);
    int unsigned sum;
    int unsigned chk;
    put_digits(0, 6, region);
    put_digits(6, 4, year);
    put_digits(10, 2, month);
    put_digits(12, 2, day);
    put_digits(14, 3, seq);
    sum = 0;
    for (int p = 0; p < 17; p++) sum += (id_buf[p] - CHAR_ZERO) * pos_weight[p];
    chk = (12 - sum % 11) % 11;
    id_buf[17] = (chk == CHECK_X) ? CHAR_X : 8'(CHAR_ZERO + chk);
  endfunction

  function automatic int unsigned rand_region();
    if ($urandom_range(9) == 0) return $urandom_range(20'hFFFFF);
    return $urandom_range(999999);
  endfunction

  function automatic int unsigned rand_table_size();
    if ($urandom_range(99) < 85) return $urandom_range(24, 1);
    return $urandom_range(70, 56);
  endfunction

  function automatic int unsigned pick_region();
    int unsigned v;
    if (loaded_regions.size() > 0 && $urandom_range(99) < 80) begin
      v = loaded_regions[$urandom_range(loaded_regions.size() - 1)];
      if (v <= 999999) return v;
    end
    return $urandom_range(999999);
  endfunction

  task automatic append_region(input int unsigned v);
    send_req(make_req(OP_APPEND, v, $urandom()));
    if (loaded_regions.size() < TABLE_DEPTH) loaded_regions.push_back(v);
  endtask

  task automatic clear_table();
    send_req(make_req(OP_CLEAR, $urandom(), $urandom()));
    loaded_regions.delete();
  endtask

  task automatic reload_table(input int unsigned n);
    clear_table();
    repeat (n) append_region(rand_region());
  endtask

  // Send the composed number; when noisy, mix in ignored and table requests
  task automatic send_id(input bit noisy);
    for (int i = 0; i < ID_CHARS; i++) begin
      if (noisy && $urandom_range(99) < 2) begin
        send_req(make_req(OP_UNUSED, $urandom(), $urandom()));
      end
      if (noisy && $urandom_range(99) < 2) append_region(rand_region());
      // abandon the number part way through
      if (noisy && i > 0 && $urandom_range(299) == 0) begin
        reload_table(rand_table_size());
        return;
      end
      send_req(make_req(OP_CHAR, $urandom(), id_buf[i]));
    end
  endtask

  task automatic send_random_number();
    int unsigned region;
    int unsigned year;
    int unsigned month;
    int unsigned day;
    int unsigned seq;
    int unsigned lo;
    int unsigned hi;
    int unsigned roll;
    region = pick_region();
    lo = (yr_min > 3) ? yr_min - 3 : 0;
    hi = (yr_max + 3 < 9999) ? yr_max + 3 : 9999;
    if (lo <= hi && $urandom_range(99) < 85) begin
      year = $urandom_range(hi, lo);
    end else begin
      year = $urandom_range(9999);
    end
    month = ($urandom_range(99) < 88) ? $urandom_range(12, 1) : $urandom_range(99);
    roll = $urandom_range(99);
    if (roll < 5) begin
      // Feb 29 on century and four-year boundaries
      month = 2;
      day   = 29;
      year  = $urandom_range(1) ? 100 * $urandom_range(99) : 4 * $urandom_range(2499);
    end else if (roll < 80) begin
      day = $urandom_range(month_length(year, month), 1);
    end else if (roll < 88) begin
      day = month_length(year, month) + 1;
    end else begin
      day = $urandom_range(99);
    end
    seq = ($urandom_range(99) < 6) ? 0 : $urandom_range(999, 1);
    compose_id(region, year, month, day, seq);
    // corrupt a digit or the check character now and then
    roll = $urandom_range(99);
    if (roll < 6) begin
      id_buf[$urandom_range(16)] = 8'($urandom());
    end else if (roll < 10) begin
      id_buf[17] = 8'($urandom());
    end else if (roll < 13) begin
      id_buf[17] = (id_buf[17] == CHAR_X) ? CHAR_LOWER_X : 8'(CHAR_ZERO + $urandom_range(9));
    end
    send_id(1'b1);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_numbers();
    int unsigned seq;
    src_idle_pct = 20;
    snk_idle_pct = 30;
    clear_table();
    append_region(110101);
    append_region(0);
    append_region(999999);
    append_region(20'hFFFFF);
    // leap by 400: valid, odd sequence
    compose_id(110101, 2000, 2, 29, 1);
    send_id(1'b0);
    // century year is not leap
    compose_id(999999, 1900, 2, 29, 2);
    send_id(1'b0);
    compose_id(999999, 1900, 2, 28, 2);
    send_id(1'b0);
    // lowest region code, top of the year range, highest sequence
    compose_id(0, 2011, 12, 31, 999);
    send_id(1'b0);
    // day past the end of April, month 13, day zero
    compose_id(110101, 2004, 4, 31, 7);
    send_id(1'b0);
    compose_id(110101, 2004, 13, 1, 7);
    send_id(1'b0);
    compose_id(110101, 2004, 1, 0, 7);
    send_id(1'b0);
    // zero sequence, then a region that was never loaded
    compose_id(110101, 1980, 6, 15, 0);
    send_id(1'b0);
    compose_id(123456, 1980, 6, 15, 5);
    send_id(1'b0);
    // check value ten: upper case matches, lower case does not
    seq = 1;
    compose_id(110101, 1988, 7, 15, seq);
    while (id_buf[17] != CHAR_X) begin
      seq++;
      compose_id(110101, 1988, 7, 15, seq);
    end
    send_id(1'b0);
    id_buf[17] = CHAR_LOWER_X;
    send_id(1'b0);
    // characters just outside the digit range, and the top byte
    compose_id(110101, 1990, 1, 1, 3);
    id_buf[0] = 8'h2F;
    send_id(1'b0);
    compose_id(110101, 1990, 1, 1, 3);
    id_buf[16] = 8'h3A;
    send_id(1'b0);
    compose_id(110101, 1990, 1, 1, 3);
    id_buf[8] = 8'hFF;
    send_id(1'b0);
    // unused opcode and an append part way through leave the number alone
    compose_id(654321, 1995, 3, 9, 11);
    for (int i = 0; i < ID_CHARS; i++) begin
      if (i == 5) send_req(make_req(OP_UNUSED, $urandom(), $urandom()));
      if (i == 9) append_region(654321);
      send_req(make_req(OP_CHAR, $urandom(), id_buf[i]));
    end
    // clear part way through restarts the number and empties the table
    compose_id(110101, 1970, 5, 20, 44);
    for (int i = 0; i < 7; i++) send_req(make_req(OP_CHAR, $urandom(), id_buf[i]));
    clear_table();
    send_id(1'b0);
    append_region(110101);
    send_id(1'b0);
  endtask

  task automatic test_year_range();
    set_year_range(0, 9999);
    clear_table();
    append_region(500100);
    compose_id(500100, 0, 2, 29, 1);
    send_id(1'b0);
    compose_id(500100, 9999, 12, 31, 2);
    send_id(1'b0);
    compose_id(500100, 2100, 2, 29, 3);
    send_id(1'b0);
    // single-year range
    set_year_range(2000, 2000);
    compose_id(500100, 2000, 6, 1, 4);
    send_id(1'b0);
    compose_id(500100, 1999, 6, 1, 4);
    send_id(1'b0);
    compose_id(500100, 2001, 6, 1, 4);
    send_id(1'b0);
    // an empty range, and one above any four-digit year, reject everything
    set_year_range(2011, 1900);
    compose_id(500100, 2000, 6, 1, 5);
    send_id(1'b0);
    set_year_range(16383, 16383);
    compose_id(500100, 9999, 6, 1, 5);
    send_id(1'b0);
  endtask

  task automatic test_table_full();
    set_year_range(1900, 2011);
    clear_table();
    for (int i = 0; i < TABLE_DEPTH + 2; i++) append_region(300000 + i);
    // last entry found, first past the depth dropped
    compose_id(300000 + TABLE_DEPTH - 1, 1999, 9, 30, 8);
    send_id(1'b0);
    compose_id(300000 + TABLE_DEPTH, 1999, 9, 30, 8);
    send_id(1'b0);
    compose_id(300000, 1999, 9, 30, 9);
    send_id(1'b0);
  endtask

  task automatic test_random_phase(input int unsigned src_pct, snk_pct, n, lo, hi);
    int unsigned start;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    set_year_range(lo, hi);
    reload_table(rand_table_size());
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(99) < 4) begin
        // a burst of arbitrary requests, then resynchronise
        repeat ($urandom_range(6, 1)) begin
          send_req(make_req($urandom_range(3), $urandom(), $urandom()));
        end
        reload_table(rand_table_size());
      end else begin
        send_random_number();
      end
    end
  endtask

  // Hold the result side off long enough for the block to back up
  task automatic test_backpressure();
    wait_quiet();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    reload_table(4);
    hold_left = HOLD_CYCLES;
    repeat (6) send_random_number();
  endtask

  initial begin
    int          w;
    int unsigned yr_lo;
    w = 1;
    for (int p = 16; p >= 0; p--) begin
      w = (w * 2) % 11;
      pos_weight[p] = w;
    end
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_left    = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    error_count  = 0;
    yr_min       = MIN_YEAR_RESET;
    yr_max       = MAX_YEAR_RESET;
    n_regions    = 0;
    restart_number();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_numbers();
    test_year_range();
    test_table_full();
    test_random_phase(11, 74, 240, 1900, 2011);
    test_random_phase(74, 11, 240, 0, 9999);
    yr_lo = $urandom_range(2050, 1850);
    test_random_phase(0, 0, 240, yr_lo, yr_lo + $urandom_range(150));
    test_backpressure();

    wait_quiet();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
